### sv/record_table_sort_engine_defines.svh
// ============================================================================
// Record table sort engine assertion macros
// Shared concurrent assertion forms used by the RTL of the record table.
// ============================================================================
`ifndef RECORD_TABLE_SORT_ENGINE_DEFINES_SVH
`define RECORD_TABLE_SORT_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RTSE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RTSE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/rtse_pkg.sv
// ============================================================================
// Record table sort engine package
// Request, response and record types, status and operation codes, and the
// sequencer states shared by the record table RTL.
// ============================================================================
`default_nettype none

package rtse_pkg;

  // Operation codes carried by a request.
  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_REMOVE = 2'd1,
    OP_SORT   = 2'd2,
    OP_LIST   = 2'd3
  } opcode_e;

  // Status codes carried by a response.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_INDEX = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_RESP,
    S_REM_RD,
    S_REM_WR,
    S_SORT_LD0,
    S_SORT_LD1,
    S_SORT_RD,
    S_SORT_CMP,
    S_SORT_END,
    S_LIST_RD,
    S_LIST_OUT
  } state_e;

  typedef struct packed {
    opcode_e     opcode;
    logic [23:0] price;
    logic        flag;
    logic [15:0] tag;
    logic [5:0]  position;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic [5:0]  entry_index;
    logic [23:0] entry_price;
    logic        entry_flag;
    logic [15:0] entry_tag;
    logic [29:0] running_total;
    logic        last;
  } rsp_t;

  // One table entry as held in the record memory.
  typedef struct packed {
    logic [23:0] price;
    logic        flag;
    logic [15:0] tag;
  } record_t;

  localparam int unsigned RecordW    = $bits(record_t);
  localparam int unsigned MaxResults = 64;
  localparam logic [29:0] TotalMax   = 30'h3FFF_FFFF;

endpackage

`default_nettype wire

### sv/record_table_sort_engine.sv
// ============================================================================
// Record table sort engine
// Bounded table of price/flag/tag records with append, remove, stable
// bubble sort by price and a list with running total.
// ============================================================================
// The block takes one request at a time and holds off new requests (stall
// high) until the work of the current one is done; a finished response sits
// in an output register, so the next request can be taken while it waits.
// All records live in one RAM with a single write and a single read port and
// a registered read. Append, and sort of at most one record, go straight to
// the response. Remove reads and writes back each record that shifts down.
// In a sort, each bubble pass reloads its first record and then does a read
// and a compare-swap write per step. List loads one response per record and
// reads the next record only after that response is taken into the output
// register, so it waits while the output side stalls. No clearing pass is
// needed after reset.
`default_nettype none
`include "record_table_sort_engine_defines.svh"

module record_table_sort_engine #(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire rtse_pkg::req_t in_req_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output rtse_pkg::rsp_t      out_rsp_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = (CW > 6) ? CW : 6;
  localparam int unsigned LW = (CW > 7) ? CW : 7;

  rtse_pkg::state_e  state_q, state_d;
  logic [CW-1:0]     count_q, count_d;
  logic [AW-1:0]     ptr_q, ptr_d;
  logic [AW-1:0]     lim_q, lim_d;
  rtse_pkg::record_t held_q, held_d;
  logic [29:0]       total_q, total_d;
  rtse_pkg::status_e status_q, status_d;
  logic              out_valid_q, out_valid_d;
  rtse_pkg::rsp_t    out_q, out_d;

  logic              in_accept;
  logic              out_free;
  logic              out_load;
  rtse_pkg::rsp_t    out_data;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  rtse_pkg::record_t ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  rtse_pkg::record_t ram_rdata;

  logic              table_full;
  logic              table_empty;
  logic              bad_pos;
  logic [CW-1:0]     ptr_plus;
  logic [LW-1:0]     shown;
  logic              list_last;
  logic [30:0]       sum_wide;
  logic [29:0]       total_sat;
  logic              swap;

  // Record memory.
  rtse_ram #(
    .Width (rtse_pkg::RecordW),
    .Depth (CAPACITY)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_we),
    .wr_addr_i (ram_waddr),
    .wr_data_i (ram_wdata),
    .rd_en_i   (ram_re),
    .rd_addr_i (ram_raddr),
    .rd_data_o (ram_rdata)
  );

  // Handshake and shared terms.
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign table_full  = (count_q == CW'(CAPACITY));
  assign table_empty = (count_q == '0);
  assign bad_pos     = (PW'(in_req_i.position) >= PW'(count_q));
  assign ptr_plus    = CW'(ptr_q) + CW'(1);
  assign shown       = (LW'(count_q) < LW'(rtse_pkg::MaxResults)) ?
                       LW'(count_q) : LW'(rtse_pkg::MaxResults);
  assign list_last   = ((LW'(ptr_q) + LW'(1)) == shown);
  assign sum_wide    = {1'b0, total_q} + 31'(ram_rdata.price);
  assign total_sat   = sum_wide[30] ? rtse_pkg::TotalMax : sum_wide[29:0];
  assign swap        = (held_q.price > ram_rdata.price);

  // Next-state logic of the sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rtse_pkg::S_IDLE: begin
        if (in_accept) begin
          unique case (in_req_i.opcode)
            rtse_pkg::OP_APPEND: state_d = rtse_pkg::S_RESP;
            rtse_pkg::OP_REMOVE: begin
              state_d = (table_empty || bad_pos) ? rtse_pkg::S_RESP : rtse_pkg::S_REM_RD;
            end
            rtse_pkg::OP_SORT: begin
              state_d = (count_q <= CW'(1)) ? rtse_pkg::S_RESP : rtse_pkg::S_SORT_LD0;
            end
            rtse_pkg::OP_LIST: begin
              state_d = table_empty ? rtse_pkg::S_RESP : rtse_pkg::S_LIST_RD;
            end
          endcase
        end
      end
      rtse_pkg::S_RESP: begin
        if (out_free) begin
          state_d = rtse_pkg::S_IDLE;
        end
      end
      rtse_pkg::S_REM_RD: begin
        state_d = (ptr_plus < count_q) ? rtse_pkg::S_REM_WR : rtse_pkg::S_RESP;
      end
      rtse_pkg::S_REM_WR:   state_d = rtse_pkg::S_REM_RD;
      rtse_pkg::S_SORT_LD0: state_d = rtse_pkg::S_SORT_LD1;
      rtse_pkg::S_SORT_LD1: state_d = rtse_pkg::S_SORT_RD;
      rtse_pkg::S_SORT_RD:  state_d = rtse_pkg::S_SORT_CMP;
      rtse_pkg::S_SORT_CMP: begin
        state_d = (ptr_plus == CW'(lim_q)) ? rtse_pkg::S_SORT_END : rtse_pkg::S_SORT_RD;
      end
      rtse_pkg::S_SORT_END: begin
        state_d = (lim_q == AW'(1)) ? rtse_pkg::S_RESP : rtse_pkg::S_SORT_LD0;
      end
      rtse_pkg::S_LIST_RD:  state_d = rtse_pkg::S_LIST_OUT;
      rtse_pkg::S_LIST_OUT: begin
        if (out_free) begin
          state_d = list_last ? rtse_pkg::S_IDLE : rtse_pkg::S_LIST_RD;
        end
      end
      default: state_d = rtse_pkg::S_IDLE;
    endcase
  end

  // Memory accesses, datapath updates and response data per state.
  always_comb begin
    count_d   = count_q;
    ptr_d     = ptr_q;
    lim_d     = lim_q;
    held_d    = held_q;
    total_d   = total_q;
    status_d  = status_q;
    ram_we    = 1'b0;
    ram_waddr = ptr_q;
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = ptr_q;
    out_load  = 1'b0;
    out_data  = '0;
    unique case (state_q)
      rtse_pkg::S_IDLE: begin
        if (in_accept) begin
          unique case (in_req_i.opcode)
            rtse_pkg::OP_APPEND: begin
              if (table_full) begin
                status_d = rtse_pkg::ST_FULL;
              end else begin
                status_d  = rtse_pkg::ST_OK;
                ram_we    = 1'b1;
                ram_waddr = AW'(count_q);
                ram_wdata = '{price: in_req_i.price, flag: in_req_i.flag,
                              tag: in_req_i.tag};
                count_d   = count_q + CW'(1);
              end
            end
            rtse_pkg::OP_REMOVE: begin
              if (table_empty) begin
                status_d = rtse_pkg::ST_EMPTY;
              end else if (bad_pos) begin
                status_d = rtse_pkg::ST_BAD_INDEX;
              end else begin
                status_d = rtse_pkg::ST_OK;
                ptr_d    = AW'(in_req_i.position);
              end
            end
            rtse_pkg::OP_SORT: begin
              status_d = rtse_pkg::ST_OK;
              lim_d    = AW'(count_q - CW'(1));
            end
            rtse_pkg::OP_LIST: begin
              status_d = table_empty ? rtse_pkg::ST_EMPTY : rtse_pkg::ST_OK;
              ptr_d    = '0;
              total_d  = '0;
            end
          endcase
        end
      end
      rtse_pkg::S_RESP: begin
        out_load        = out_free;
        out_data.status = status_q;
        out_data.last   = 1'b1;
      end
      // Remove: move each later record down by one, then drop the count.
      rtse_pkg::S_REM_RD: begin
        if (ptr_plus < count_q) begin
          ram_re    = 1'b1;
          ram_raddr = AW'(ptr_plus);
        end else begin
          count_d = count_q - CW'(1);
        end
      end
      rtse_pkg::S_REM_WR: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_q;
        ram_wdata = ram_rdata;
        ptr_d     = ptr_q + AW'(1);
      end
      // Sort: each pass carries the largest record seen so far to the end.
      rtse_pkg::S_SORT_LD0: begin
        ram_re    = 1'b1;
        ram_raddr = '0;
        ptr_d     = '0;
      end
      rtse_pkg::S_SORT_LD1: begin
        held_d = ram_rdata;
      end
      rtse_pkg::S_SORT_RD: begin
        ram_re    = 1'b1;
        ram_raddr = AW'(ptr_plus);
      end
      rtse_pkg::S_SORT_CMP: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_q;
        ptr_d     = ptr_q + AW'(1);
        if (swap) begin
          ram_wdata = ram_rdata;
        end else begin
          ram_wdata = held_q;
          held_d    = ram_rdata;
        end
      end
      rtse_pkg::S_SORT_END: begin
        ram_we    = 1'b1;
        ram_waddr = lim_q;
        ram_wdata = held_q;
        lim_d     = lim_q - AW'(1);
      end
      // List: one record per response with a saturating running total.
      rtse_pkg::S_LIST_RD: begin
        ram_re    = 1'b1;
        ram_raddr = ptr_q;
      end
      rtse_pkg::S_LIST_OUT: begin
        out_load               = out_free;
        out_data.status        = rtse_pkg::ST_OK;
        out_data.entry_index   = 6'(ptr_q);
        out_data.entry_price   = ram_rdata.price;
        out_data.entry_flag    = ram_rdata.flag;
        out_data.entry_tag     = ram_rdata.tag;
        out_data.running_total = total_sat;
        out_data.last          = list_last;
        if (out_free) begin
          total_d = total_sat;
          ptr_d   = ptr_q + AW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Output register: loads a response when it is empty or being taken.
  always_comb begin
    out_d       = out_load ? out_data : out_q;
    out_valid_d = out_load || (out_valid_q && out_stall_i);
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rtse_pkg::S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    ptr_q    <= ptr_d;
    lim_q    <= lim_d;
    held_q   <= held_d;
    total_q  <= total_d;
    status_q <= status_d;
    out_q    <= out_d;
  end

  assign in_stall_o  = (state_q != rtse_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // Checks on the sequencer and the record count.
  `RTSE_ASSERT_NOW(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= CW'(CAPACITY), "record count above capacity")
  `RTSE_ASSERT_NOW(a_one_access, clk_i, rst_ni, ram_we, !ram_re, "record memory read and written in one cycle")
  `RTSE_ASSERT_NEXT(a_append_count, clk_i, rst_ni, in_accept && (in_req_i.opcode == rtse_pkg::OP_APPEND) && !table_full, count_q == ($past(count_q) + CW'(1)), "append did not grow the table")
  `RTSE_ASSERT_NEXT(a_sort_count, clk_i, rst_ni, state_q == rtse_pkg::S_SORT_CMP, $stable(count_q), "sort step changed the record count")
  `RTSE_ASSERT_NEXT(a_list_last, clk_i, rst_ni, (state_q == rtse_pkg::S_LIST_OUT) && out_free && list_last, out_valid_q && out_q.last, "final listed record not marked last")

endmodule

`default_nettype wire

### sv/rtse_ram.sv
// ============================================================================
// Record table RAM
// Generic single-write, single-read synchronous RAM with a registered read.
// ============================================================================
`default_nettype none

module rtse_ram #(
  parameter int unsigned Width = 41,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(Depth)-1:0] wr_addr_i,
  input  wire logic [Width-1:0]         wr_data_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]              rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  // Write port and registered read port; read data holds when not enabled.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire
